FILE: rtl/mf2d_pkg.sv
// Shared types, constants and state encoding of the 2-D median filter.
package mf2d_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 3;
    localparam int HEIGHT_LIMIT   = 4096;

    localparam int PIX_W        = 8;
    localparam int ROW_W        = 12;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_RADIUS_W = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_FLUSH,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic accept;
        logic setup;
        logic read;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic back_zero;
        logic win_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/mf2d_sorter.sv
// Insertion sorter that collects one window and presents its median.
module mf2d_sorter #(
    parameter int N = 49
) (
    input  logic                       clk,
    input  logic                       preset,
    input  logic                       ins_valid,
    input  logic [mf2d_pkg::PIX_W-1:0] ins_data,
    input  logic [$clog2(N)-1:0]       mid,
    output logic [mf2d_pkg::PIX_W-1:0] median
);
    import mf2d_pkg::*;

    logic [PIX_W-1:0] sort_reg  [N];
    logic [PIX_W-1:0] sort_next [N];
    logic             gt        [N];

    // Empty slots hold the largest value, so they always sort behind real pixels.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            gt[i] = sort_reg[i] > ins_data;
        end
        sort_next[0] = gt[0] ? ins_data : sort_reg[0];
        for (int i = 1; i < N; i++)
        begin
            if (!gt[i])
            begin
                sort_next[i] = sort_reg[i];
            end
            else if (!gt[i-1])
            begin
                sort_next[i] = ins_data;
            end
            else
            begin
                sort_next[i] = sort_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (preset)
            begin
                sort_reg[i] <= {PIX_W{1'b1}};
            end
            else if (ins_valid)
            begin
                sort_reg[i] <= sort_next[i];
            end
        end
    end

    assign median = sort_reg[mid];

endmodule

FILE: rtl/mf2d_ctrl.sv
// Controller state machine that sequences one window pass per result.
module mf2d_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mf2d_pkg::dp_status_t status,
    output mf2d_pkg::dp_cmd_t    cmd
);
    import mf2d_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.emit)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (status.back_zero)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (status.win_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_READ:
            begin
                cmd.read = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd = '0;
            end
            ST_HOLD:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/mf2d_datapath.sv
// Datapath: registers, frame positions, line store, window addressing and output register.
module mf2d_datapath #(
    parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = mf2d_pkg::MAX_RADIUS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mf2d_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output mf2d_pkg::out_item_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mf2d_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mf2d_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  mf2d_pkg::dp_cmd_t                cmd,
    output mf2d_pkg::dp_status_t             status
);
    import mf2d_pkg::*;

    localparam int WIN   = 2 * MAX_RADIUS + 1;
    localparam int NWIN  = WIN * WIN;
    localparam int DEPTH = WIN * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int DXW   = $clog2(WIN);
    localparam int MIDW  = $clog2(NWIN);
    localparam int LAGW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
    localparam int SCW   = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + 1) + 1;
    localparam int VRW   = ROW_W + 2;

    function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW:0] b);
        logic [AW+1:0] s;
        s = (AW+2)'(a) + (AW+2)'(b);
        if (s >= (AW+2)'(DEPTH))
        begin
            s = s - (AW+2)'(DEPTH);
        end
        return AW'(s);
    endfunction

    function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [AW:0] b);
        logic [AW+1:0] s;
        if ((AW+1)'(a) >= b)
        begin
            s = (AW+2)'(a) - (AW+2)'(b);
        end
        else
        begin
            s = (AW+2)'(a) + (AW+2)'(DEPTH) - (AW+2)'(b);
        end
        return AW'(s);
    endfunction

    // Configuration registers and their effective values.
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [CFG_RADIUS_W-1:0] radius_reg;
    logic [WW-1:0]           w_eff;
    logic [CFG_HEIGHT_W-1:0] h_eff;
    logic [RW-1:0]           r_eff;
    logic [LAGW-1:0]         lag;
    logic [DXW-1:0]          twor;
    logic [MIDW-1:0]         mid;
    logic                    cfg_hit;

    // Frame positions.
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [COLW-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic             frame_full_reg, frame_full_next;
    logic [LAGW-1:0]  pending_reg, pending_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next, out_base_reg, out_base_next;

    // Window sequencer.
    logic [RW-1:0]           back_reg, back_next;
    logic [DXW-1:0]          dx_reg, dx_next, dy_reg, dy_next;
    logic signed [VRW-1:0]   vr_reg, vr_next, vr_inc, h_lim;
    logic [AW-1:0]           rowaddr_reg, rowaddr_next, rd_addr;
    logic signed [SCW-1:0]   cc_v;
    logic [COLW-1:0]         cc;
    logic                    rd_valid_reg;
    logic [PIX_W-1:0]        rd_data_reg;
    logic [PIX_W-1:0]        mem [DEPTH];

    logic             push_ok, mem_we, last_out, restart;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg;
    logic [PIX_W-1:0] median;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = CFG_HEIGHT_W'(1);
        end
        else if (32'(height_reg) > 32'(HEIGHT_LIMIT))
        begin
            h_eff = CFG_HEIGHT_W'(HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = height_reg;
        end
        if (radius_reg == '0)
        begin
            r_eff = RW'(1);
        end
        else if (32'(radius_reg) > 32'(MAX_RADIUS))
        begin
            r_eff = RW'(MAX_RADIUS);
        end
        else
        begin
            r_eff = RW'(radius_reg);
        end
    end

    assign lag  = LAGW'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
    assign twor = DXW'({r_eff, 1'b0});
    assign mid  = MIDW'(2 * 32'(r_eff) * (32'(r_eff) + 1));

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == REG_IMAGE_WIDTH
                       || cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_WINDOW_RADIUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_WIDTH_W'(640);
            height_reg <= CFG_HEIGHT_W'(480);
            radius_reg <= CFG_RADIUS_W'(3);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= CFG_WIDTH_W'(cfg_data);
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                REG_WINDOW_RADIUS: radius_reg <= CFG_RADIUS_W'(cfg_data);
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    assign push_ok  = (in_data.cmd == CMD_PUSH) && !frame_full_reg;
    assign mem_we   = cmd.accept && push_ok;
    assign last_out = (32'(out_row_reg) + 1 == 32'(h_eff))
                      && (32'(out_col_reg) + 1 == 32'(w_eff));
    assign restart  = cfg_hit || (cmd.load_out && last_out);

    always_comb
    begin
        if (in_data.cmd == CMD_PUSH)
        begin
            status.emit = push_ok && (32'(pending_reg) + 1 > 32'(lag));
        end
        else
        begin
            status.emit = frame_full_reg;
        end
        status.back_zero = back_reg == '0;
        status.win_last  = (dx_reg == twor) && (dy_reg == twor);
        status.out_free  = !out_valid_reg || !out_stall;
    end

    // Frame bookkeeping: input side on a push, output side when a result is loaded; a restart clears both.
    always_comb
    begin
        in_row_next     = in_row_reg;
        in_col_next     = in_col_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        frame_full_next = frame_full_reg;
        pending_next    = pending_reg;
        wr_addr_next    = wr_addr_reg;
        out_base_next   = out_base_reg;
        if (restart)
        begin
            in_row_next     = '0;
            in_col_next     = '0;
            out_row_next    = '0;
            out_col_next    = '0;
            frame_full_next = 1'b0;
            pending_next    = '0;
            wr_addr_next    = '0;
            out_base_next   = '0;
        end
        else if (mem_we)
        begin
            pending_next = pending_reg + LAGW'(1);
            wr_addr_next = (wr_addr_reg == AW'(DEPTH - 1)) ? '0 : wr_addr_reg + AW'(1);
            if (32'(in_col_reg) + 1 >= 32'(w_eff))
            begin
                in_col_next = '0;
                if (32'(in_row_reg) + 1 >= 32'(h_eff))
                begin
                    in_row_next     = '0;
                    frame_full_next = 1'b1;
                end
                else
                begin
                    in_row_next = in_row_reg + ROW_W'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + COLW'(1);
            end
        end
        else if (cmd.load_out)
        begin
            pending_next = pending_reg - LAGW'(1);
            if (32'(out_col_reg) + 1 >= 32'(w_eff))
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + ROW_W'(1);
                out_base_next = add_mod(out_base_reg, (AW+1)'(w_eff));
            end
            else
            begin
                out_col_next = out_col_reg + COLW'(1);
            end
        end
    end

    // Window column, clamped to the row, and its line store address.
    always_comb
    begin
        cc_v = $signed(SCW'(out_col_reg)) + $signed(SCW'(dx_reg)) - $signed(SCW'(r_eff));
        if (cc_v < 0)
        begin
            cc = '0;
        end
        else if (cc_v > $signed(SCW'(w_eff)) - $signed(SCW'(1)))
        begin
            cc = COLW'(w_eff - WW'(1));
        end
        else
        begin
            cc = COLW'(cc_v);
        end
        rd_addr = add_mod(rowaddr_reg, (AW+1)'(cc));
    end

    // Rows above and below the image repeat the edge row, so the row address
    // moves only while the window row stays inside the frame.
    always_comb
    begin
        back_next    = back_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        vr_next      = vr_reg;
        rowaddr_next = rowaddr_reg;
        vr_inc       = vr_reg + $signed(VRW'(1));
        h_lim        = $signed(VRW'(h_eff)) - $signed(VRW'(1));
        if (cmd.accept)
        begin
            rowaddr_next = out_base_reg;
            back_next    = (32'(out_row_reg) < 32'(r_eff)) ? RW'(out_row_reg) : r_eff;
            vr_next      = $signed(VRW'(out_row_reg)) - $signed(VRW'(r_eff));
            dx_next      = '0;
            dy_next      = '0;
        end
        else if (cmd.setup && back_reg != '0)
        begin
            rowaddr_next = sub_mod(rowaddr_reg, (AW+1)'(w_eff));
            back_next    = back_reg - RW'(1);
        end
        else if (cmd.read)
        begin
            if (dx_reg == twor)
            begin
                dx_next = '0;
                dy_next = dy_reg + DXW'(1);
                vr_next = vr_inc;
                if (vr_inc >= $signed(VRW'(1)) && vr_inc <= h_lim)
                begin
                    rowaddr_next = add_mod(rowaddr_reg, (AW+1)'(w_eff));
                end
            end
            else
            begin
                dx_next = dx_reg + DXW'(1);
            end
        end
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            frame_full_reg <= 1'b0;
            pending_reg    <= '0;
            wr_addr_reg    <= '0;
            out_base_reg   <= '0;
            back_reg       <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            vr_reg         <= '0;
            rowaddr_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_row_reg     <= in_row_next;
            in_col_reg     <= in_col_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            frame_full_reg <= frame_full_next;
            pending_reg    <= pending_next;
            wr_addr_reg    <= wr_addr_next;
            out_base_reg   <= out_base_next;
            back_reg       <= back_next;
            dx_reg         <= dx_next;
            dy_reg         <= dy_next;
            vr_reg         <= vr_next;
            rowaddr_reg    <= rowaddr_next;
            rd_valid_reg   <= cmd.read;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr_reg] <= in_data.pixel_in;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg.pixel_out <= median;
            out_data_reg.frame_end <= last_out;
        end
    end

    mf2d_sorter #(
        .N (NWIN)
    ) u_sorter (
        .clk       (clk),
        .preset    (cmd.accept),
        .ins_valid (rd_valid_reg),
        .ins_data  (rd_data_reg),
        .mid       (mid),
        .median    (median)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pending_reg) <= 32'(lag) + 1)
        else $error("more pixels held back than the window lag allows");

    a_full_input_parked: assert property (@(posedge clk) disable iff (!rst_n)
        frame_full_reg |-> (in_row_reg == '0 && in_col_reg == '0))
        else $error("input position moved after the frame was complete");

    a_read_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> 32'(rd_addr) < 32'(DEPTH))
        else $error("window read address beyond the line store");

    a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(cmd.read))
        else $error("sorter fed without a line store read");
`endif

endmodule

FILE: rtl/median_filter_2d_replicate.sv
// Top level of the streaming 2-D median filter with replicated image borders.
//
// Input beats carry a command and a pixel: a push writes the next pixel of the
// frame in raster order, a drain fetches one of the results still pending once
// the frame is complete. Output beats carry the median of the square window
// around the next output pixel and a frame end flag on the last pixel.
// The configuration channel writes image width, height and window radius by
// index and restarts the frame; it is to be written only while the block is idle,
// which the block itself does not enforce. A beat that yields a result passes the
// setup, read, flush and hold states before the output is valid: the single read
// port of the line store fetches one window pixel per cycle into the insertion
// sorter. A beat that yields nothing is taken in the idle state.
// The output register lets the next input beat in while a result waits; a
// stalled receiver holds the block once the following result is ready.
// Reset clears all positions and restores 640 x 480 at radius 3; the line
// store needs no clearing since only pixels of the current frame are read.
module median_filter_2d_replicate #(
    parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = mf2d_pkg::MAX_RADIUS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  mf2d_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output mf2d_pkg::out_item_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mf2d_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mf2d_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mf2d_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mf2d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mf2d_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: dv/tb_median_filter_2d_replicate.sv
// Self-checking testbench for the streaming 2-D median filter.
`timescale 1ns / 1ps

module tb_median_filter_2d_replicate;
    import mf2d_pkg::*;

    localparam int STORE_DEPTH = (2 * MAX_RADIUS_DEF + 1) * MAX_WIDTH_DEF;
    localparam int LATENCY     = 80;
    localparam int CYCLE_LIMIT = 2000000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    median_filter_2d_replicate u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state of the filter.
    logic [7:0]  pix_store [STORE_DEPTH];
    int unsigned wr_row, wr_col, rd_row, rd_col;
    bit          frame_full;
    int unsigned raw_width, raw_height, raw_radius;

    in_item_t    beat_q [$];
    out_item_t   median_q [$];
    int          errors;
    bit          idle_on;
    int          hold_req;
    int          hold_served;

    function automatic int unsigned cur_width();
        if (raw_width == 0) return 1;
        if (raw_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return raw_width;
    endfunction

    function automatic int unsigned cur_height();
        if (raw_height == 0) return 1;
        if (raw_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return raw_height;
    endfunction

    function automatic int unsigned cur_radius();
        if (raw_radius == 0) return 1;
        if (raw_radius > MAX_RADIUS_DEF) return MAX_RADIUS_DEF;
        return raw_radius;
    endfunction

    function automatic void restart_frame();
        wr_row = 0;
        wr_col = 0;
        rd_row = 0;
        rd_col = 0;
        frame_full = 1'b0;
    endfunction

    function automatic logic [7:0] window_median();
        logic [7:0] vals [49];
        logic [7:0] v;
        int w, h, r, n, k, rr, cc;
        w = cur_width();
        h = cur_height();
        r = cur_radius();
        n = 0;
        for (int dy = -r; dy <= r; dy++) begin
            rr = int'(rd_row) + dy;
            if (rr < 0) rr = 0;
            if (rr > h - 1) rr = h - 1;
            for (int dx = -r; dx <= r; dx++) begin
                cc = int'(rd_col) + dx;
                if (cc < 0) cc = 0;
                if (cc > w - 1) cc = w - 1;
                v = pix_store[(rr * w + cc) % STORE_DEPTH];
                k = n;
                while (k > 0 && vals[k-1] > v) begin
                    vals[k] = vals[k-1];
                    k--;
                end
                vals[k] = v;
                n++;
            end
        end
        return vals[n/2];
    endfunction

    function automatic void emit_median();
        out_item_t res;
        bit last;
        last = (rd_row == cur_height() - 1) && (rd_col == cur_width() - 1);
        res.pixel_out = window_median();
        res.frame_end = last;
        median_q.push_back(res);
        if (last) begin
            restart_frame();
        end else begin
            rd_col++;
            if (rd_col >= cur_width()) begin
                rd_col = 0;
                rd_row++;
            end
        end
    endfunction

    function automatic void predict_beat(in_item_t b);
        int unsigned w, h, r, received;
        w = cur_width();
        h = cur_height();
        r = cur_radius();
        if (b.cmd == CMD_DRAIN) begin
            if (frame_full) emit_median();
            return;
        end
        if (frame_full) return;
        pix_store[(wr_row * w + wr_col) % STORE_DEPTH] = b.pixel_in;
        wr_col++;
        if (wr_col >= w) begin
            wr_col = 0;
            wr_row++;
        end
        if (wr_row >= h) begin
            wr_row = 0;
            wr_col = 0;
            frame_full = 1'b1;
            received = w * h;
        end else begin
            received = wr_row * w + wr_col;
        end
        if (rd_row * w + rd_col + r * w + r < received) emit_median();
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: offers queued beats, with random bursts of idle cycles.
    int in_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   = 0;
        end else begin
            if (in_valid && !in_stall) predict_beat(in_data);
            if (!(in_valid && in_stall)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (beat_q.size() > 0) begin
                    if (idle_on && $urandom_range(0, 7) == 0) begin
                        in_gap = $urandom_range(1, 7) - 1;
                        in_valid <= 1'b0;
                    end else begin
                        in_valid <= 1'b1;
                        in_data  <= beat_q.pop_front();
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat and drives the receiver stall.
    int out_gap;
    int cycles;
    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            out_stall   <= 1'b0;
            out_gap     = 0;
            cycles      = 0;
            hold_served = 0;
        end else begin
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
            if (out_valid && !out_stall) begin
                if (median_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: pixel_out=%0d frame_end=%0b",
                                 out_data.pixel_out, out_data.frame_end);
                end else begin
                    want = median_q.pop_front();
                    if (out_data.pixel_out !== want.pixel_out ||
                        out_data.frame_end !== want.frame_end) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: pixel_out exp %0d got %0d, frame_end exp %0b got %0b",
                                     want.pixel_out, out_data.pixel_out,
                                     want.frame_end, out_data.frame_end);
                    end
                end
            end
            if (hold_served < hold_req) begin
                hold_served++;
                out_gap = 600;
                out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(1, 7) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_idle();
        while (beat_q.size() > 0 || in_valid || median_q.size() > 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_IMAGE_WIDTH) raw_width = val & 32'h7FF;
        else if (idx == REG_IMAGE_HEIGHT) raw_height = val & 32'h1FFF;
        else raw_radius = val & 32'h3;
        restart_frame();
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned r);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_WINDOW_RADIUS, r);
    endtask

    function automatic void queue_beat(logic c, logic [7:0] p);
        in_item_t b;
        b.cmd      = c;
        b.pixel_in = p;
        beat_q.push_back(b);
    endfunction

    // One frame of random pixels, then drains; noise mixes in early drains
    // and pushes that arrive while results are still pending.
    function automatic int queue_frame(int unsigned npix, int unsigned ndrain, bit noisy);
        int cnt;
        cnt = 0;
        for (int i = 0; i < npix; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                queue_beat(CMD_DRAIN, 8'($urandom));
                cnt++;
            end
            queue_beat(CMD_PUSH, 8'($urandom));
            cnt++;
        end
        for (int i = 0; i < ndrain; i++) begin
            if (noisy && $urandom_range(0, 6) == 0) begin
                queue_beat(CMD_PUSH, 8'($urandom));
                cnt++;
            end
            queue_beat(CMD_DRAIN, 8'($urandom));
            cnt++;
        end
        return cnt;
    endfunction

    initial begin
        int sent, w, h, r;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors    = 0;
        idle_on   = 1'b1;
        hold_req  = 0;
        for (int i = 0; i < STORE_DEPTH; i++) pix_store[i] = '0;
        raw_width  = 640;
        raw_height = 480;
        raw_radius = 3;
        restart_frame();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: drain with nothing pending, extreme pixels, a push that is
        // ignored while results are pending, and a drain past the frame end.
        set_geometry(4, 3, 1);
        queue_beat(CMD_DRAIN, 8'hFF);
        queue_beat(CMD_PUSH, 8'h00);
        queue_beat(CMD_PUSH, 8'hFF);
        for (int i = 0; i < 10; i++) queue_beat(CMD_PUSH, (i % 2) ? 8'hAA : 8'h55);
        queue_beat(CMD_PUSH, 8'h7F);
        for (int i = 0; i < 6; i++) queue_beat(CMD_DRAIN, 8'h00);

        // Zero registers act as the smallest geometry.
        set_geometry(0, 0, 0);
        queue_beat(CMD_PUSH, 8'h80);
        queue_beat(CMD_DRAIN, 8'h01);
        queue_beat(CMD_DRAIN, 8'h02);

        // Random frames of small size.
        sent = 0;
        while (sent < 380) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            r = $urandom_range(0, 3);
            set_geometry(w, h, r);
            if (sent > 200 && hold_req == 0) hold_req = 1;
            for (int f = 0; f < 2; f++) sent += queue_frame(w * h, w * h, 1'b1);
        end

        // Oversized height; a few rows and then a restart by a register write.
        set_geometry(2, 8191, 2);
        void'(queue_frame(40, 0, 1'b0));

        // Oversized width clamps to the widest row; a partial row stays within
        // the lag, so neither the pushes nor the drains give a result.
        set_geometry(2047, 1, 3);
        void'(queue_frame(40, 4, 1'b0));

        // Last part: no idling on either side.
        wait_idle();
        idle_on = 1'b0;
        set_geometry(8, 5, 3);
        for (int f = 0; f < 2; f++) void'(queue_frame(40, 40, 1'b1));

        wait_idle();
        if (errors == 0 && median_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
